// File: rtl/core/rtos_tick_delay_slice_unit_defines.svh
// ----------------------------------------------------------------------------
// RTOS tick unit assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef RTOS_TICK_DELAY_SLICE_UNIT_DEFINES_SVH
`define RTOS_TICK_DELAY_SLICE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define RTDS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rtds assertion failed");
`define RTDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtds implication failed");
`define RTDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtds next-cycle check failed");
`else
`define RTDS_ASSERT(lbl, clk, rstn, prop)
`define RTDS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RTDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/rtds_pkg.sv
// ----------------------------------------------------------------------------
// rtds_pkg
// Shared types and constants of the RTOS tick, delay and slice unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtds_pkg;

  localparam int unsigned TaskCountDefault = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_SETRUN = 2'd2;

  typedef enum logic [1:0] {
    KIND_SWITCH  = 2'd0,
    KIND_PREEMPT = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLICE,
    ST_LEVEL,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        delayed;
    logic [31:0] delay;
    logic [7:0]  level;
  } task_entry_t;

endpackage

`default_nettype wire

// File: rtl/core/rtos_tick_delay_slice_unit.sv
// ----------------------------------------------------------------------------
// rtos_tick_delay_slice_unit
// Kernel tick engine: run-time counter, time slice and task delay table.
//
// Usage: requests enter on in_valid_i/in_ready_o; op_i selects tick, task
// entry write or set-running-task. Results leave on out_valid_o/out_ready_i,
// one result register deep. Each request ends with one done result (last_o).
// A tick may first give a slice-expired switch result and one preempt result
// per woken task that outranks the running task, in task index order.
// A write or set-running request goes from acceptance straight to the done
// state. A tick steps through accept, slice, running-level read, a walk over
// every task entry in index order, since the task table has one read and one
// write port, and done. The unit takes no new request until the done result
// is loaded into the result register.
// A stalled receiver holds the sequencer at the next result to be loaded.
// Reset (rst_ni low, asynchronous) clears the table valid bits, so all task
// entries read as zero, plus running task, slice and run-time counter. No
// clearing pass is needed; the unit is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtos_tick_delay_slice_unit_defines.svh"

module rtos_tick_delay_slice_unit #(
  parameter int unsigned TASK_COUNT = rtds_pkg::TaskCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] elapsed_ticks_i,
  input  wire logic        in_interrupt_i,
  input  wire logic [3:0]  task_index_i,
  input  wire logic        task_delayed_i,
  input  wire logic [31:0] task_delay_i,
  input  wire logic [7:0]  task_priority_i,
  input  wire logic [15:0] slice_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [3:0]       task_index_res_o,
  output logic [31:0]      run_time_o,
  output logic             last_o
);

  localparam int unsigned IdxW = $clog2(TASK_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_COUNT - 1);

  rtds_pkg::state_e state_q, state_d;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] running_q, running_d;
  logic [15:0]     slice_q, slice_d;
  logic [31:0]     run_time_q, run_time_d;
  logic [15:0]     ticks_q, ticks_d;
  logic            irq_q, irq_d;
  logic [7:0]      run_level_q, run_level_d;

  logic            out_valid_q, out_valid_d;
  rtds_pkg::kind_e kind_q, kind_d;
  logic [3:0]      res_idx_q, res_idx_d;
  logic            last_q, last_d;
  logic [31:0]     res_time_q, res_time_d;

  rtds_pkg::task_entry_t mem [TASK_COUNT];
  logic [TASK_COUNT-1:0] valid_q;
  rtds_pkg::task_entry_t rd_data_q;
  logic                  rd_valid_q;
  rtds_pkg::task_entry_t rd_entry;
  logic [IdxW-1:0]       rd_addr;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  rtds_pkg::task_entry_t mem_wdata;

  logic        slot_free;
  logic        idx_in_range;
  logic [16:0] slice_diff;
  logic [15:0] slice_sat;
  logic [32:0] delay_diff;
  logic [31:0] delay_sat;
  logic        wake;
  logic        preempt;

  assign slot_free    = !out_valid_q || out_ready_i;
  assign idx_in_range = 32'(task_index_i) < TASK_COUNT;
  assign rd_entry     = rd_valid_q ? rd_data_q : '0;

  assign slice_diff = {1'b0, slice_q} - {1'b0, ticks_q};
  assign slice_sat  = slice_diff[16] ? 16'd0 : slice_diff[15:0];
  assign delay_diff = {1'b0, rd_entry.delay} - {17'd0, ticks_q};
  assign delay_sat  = delay_diff[32] ? 32'd0 : delay_diff[31:0];
  assign wake       = rd_entry.delayed && (delay_sat == 32'd0);
  assign preempt    = wake && (rd_entry.level < run_level_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    running_d   = running_q;
    slice_d     = slice_q;
    run_time_d  = run_time_q;
    ticks_d     = ticks_q;
    irq_d       = irq_q;
    run_level_d = run_level_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    res_idx_d   = res_idx_q;
    last_d      = last_q;
    res_time_d  = res_time_q;
    in_ready_o  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    rd_addr     = '0;

    unique case (state_q)
      rtds_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ticks_d = elapsed_ticks_i;
          irq_d   = in_interrupt_i;
          state_d = rtds_pkg::ST_DONE;
          unique case (op_i)
            rtds_pkg::OP_TICK: begin
              run_time_d = run_time_q + 32'(elapsed_ticks_i);
              state_d    = rtds_pkg::ST_SLICE;
            end
            rtds_pkg::OP_WRITE: begin
              if (idx_in_range) begin
                mem_we            = 1'b1;
                mem_waddr         = IdxW'(task_index_i);
                mem_wdata.delayed = task_delayed_i;
                mem_wdata.delay   = task_delay_i;
                mem_wdata.level   = task_priority_i;
              end
            end
            rtds_pkg::OP_SETRUN: begin
              if (idx_in_range) begin
                running_d = IdxW'(task_index_i);
                slice_d   = slice_length_i;
              end
            end
            default: begin
            end
          endcase
        end
      end

      rtds_pkg::ST_SLICE: begin
        rd_addr = running_q;
        if (slice_q != 16'd0 && !irq_q) begin
          if (slice_sat == 16'd0) begin
            if (slot_free) begin
              out_valid_d = 1'b1;
              kind_d      = rtds_pkg::KIND_SWITCH;
              res_idx_d   = 4'd0;
              last_d      = 1'b0;
              res_time_d  = run_time_q;
              slice_d     = 16'd0;
              state_d     = rtds_pkg::ST_LEVEL;
            end
          end else begin
            slice_d = slice_sat;
            state_d = rtds_pkg::ST_LEVEL;
          end
        end else begin
          state_d = rtds_pkg::ST_LEVEL;
        end
      end

      rtds_pkg::ST_LEVEL: begin
        run_level_d = rd_entry.level;
        idx_d       = '0;
        rd_addr     = '0;
        state_d     = rtds_pkg::ST_WALK;
      end

      rtds_pkg::ST_WALK: begin
        rd_addr = idx_q;
        if (!preempt || slot_free) begin
          if (rd_entry.delayed) begin
            mem_we            = 1'b1;
            mem_waddr         = idx_q;
            mem_wdata.delayed = !wake;
            mem_wdata.delay   = delay_sat;
            mem_wdata.level   = rd_entry.level;
          end
          if (preempt) begin
            out_valid_d = 1'b1;
            kind_d      = rtds_pkg::KIND_PREEMPT;
            res_idx_d   = 4'(idx_q);
            last_d      = 1'b0;
            res_time_d  = run_time_q;
          end
          if (idx_q == LastIdx) begin
            rd_addr = '0;
            state_d = rtds_pkg::ST_DONE;
          end else begin
            rd_addr = idx_q + 1'b1;
            idx_d   = idx_q + 1'b1;
          end
        end
      end

      rtds_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = rtds_pkg::KIND_DONE;
          res_idx_d   = 4'd0;
          last_d      = 1'b1;
          res_time_d  = run_time_q;
          state_d     = rtds_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rtds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtds_pkg::ST_IDLE;
      idx_q       <= '0;
      running_q   <= '0;
      slice_q     <= '0;
      run_time_q  <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      running_q   <= running_d;
      slice_q     <= slice_d;
      run_time_q  <= run_time_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= valid_q[rd_addr];
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q     <= ticks_d;
    irq_q       <= irq_d;
    run_level_q <= run_level_d;
    kind_q      <= kind_d;
    res_idx_q   <= res_idx_d;
    last_q      <= last_d;
    res_time_q  <= res_time_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign task_index_res_o = res_idx_q;
  assign run_time_o       = res_time_q;
  assign last_o           = last_q;

  `RTDS_ASSERT_IMPL(a_walk_idx_bound, clk_i, rst_ni,
                    state_q == rtds_pkg::ST_WALK, idx_q <= LastIdx)
  `RTDS_ASSERT_IMPL(a_mem_we_phase, clk_i, rst_ni, mem_we,
                    state_q == rtds_pkg::ST_IDLE || state_q == rtds_pkg::ST_WALK)
  `RTDS_ASSERT_NEXT(a_slice_no_grow, clk_i, rst_ni,
                    state_q == rtds_pkg::ST_SLICE, slice_q <= $past(slice_q))
  `RTDS_ASSERT(a_last_is_done, clk_i, rst_ni,
               !out_valid_q || (last_q == (kind_q == rtds_pkg::KIND_DONE)))

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the RTOS tick, delay and slice unit
// Drives tick, task-write, set-running and unused requests through the
// valid/ready request channel, predicts every result from a local copy of
// the task table, slice and run-time counter, and checks each result field
// in order. Both sides pause at random; one phase stalls the output long.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TASKS          = rtds_pkg::TaskCountDefault;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 55;
  localparam int unsigned DRAIN_CYCLES   = TASKS + 24;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 400;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] ticks;
    logic        irq;
    logic [3:0]  idx;
    logic        delayed;
    logic [31:0] delay;
    logic [7:0]  prio;
    logic [15:0] slice;
  } tick_req_t;

  typedef struct {
    rtds_pkg::kind_e kind;
    logic [3:0]      idx;
    logic [31:0]     run_time;
    logic            last;
  } tick_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [15:0] elapsed_ticks_i;
  logic        in_interrupt_i;
  logic [3:0]  task_index_i;
  logic        task_delayed_i;
  logic [31:0] task_delay_i;
  logic [7:0]  task_priority_i;
  logic [15:0] slice_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [3:0]  task_index_res_o;
  logic [31:0] run_time_o;
  logic        last_o;

  rtos_tick_delay_slice_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .elapsed_ticks_i  (elapsed_ticks_i),
    .in_interrupt_i   (in_interrupt_i),
    .task_index_i     (task_index_i),
    .task_delayed_i   (task_delayed_i),
    .task_delay_i     (task_delay_i),
    .task_priority_i  (task_priority_i),
    .slice_length_i   (slice_length_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .task_index_res_o (task_index_res_o),
    .run_time_o       (run_time_o),
    .last_o           (last_o)
  );

  logic        task_delayed_q [TASKS];
  logic [31:0] task_delay_q [TASKS];
  logic [7:0]  task_level_q [TASKS];
  logic [3:0]  running_q;
  logic [15:0] slice_q;
  logic [31:0] run_time_q;

  tick_res_t   due_results [$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          pace_on = 1'b1;
  int unsigned burst_left = 0;
  int unsigned hold_cycles_req = 0;
  int unsigned hold_gen = 0;

  always #1 clk_i = ~clk_i;

  function automatic void push_result(rtds_pkg::kind_e kind, logic [3:0] idx, logic last);
    tick_res_t res;
    res.kind     = kind;
    res.idx      = idx;
    res.run_time = run_time_q;
    res.last     = last;
    due_results.push_back(res);
  endfunction

  function automatic void advance_tick_engine(tick_req_t r);
    logic [7:0] run_level;
    case (r.op)
      rtds_pkg::OP_TICK: begin
        run_time_q = run_time_q + {16'd0, r.ticks};
        if (slice_q != 16'd0 && !r.irq) begin
          slice_q = (slice_q >= r.ticks) ? slice_q - r.ticks : 16'd0;
          if (slice_q == 16'd0) push_result(rtds_pkg::KIND_SWITCH, 4'd0, 1'b0);
        end
        run_level = task_level_q[running_q];
        for (int i = 0; i < TASKS; i++) begin
          if (task_delayed_q[i]) begin
            task_delay_q[i] = (task_delay_q[i] >= {16'd0, r.ticks}) ?
                              task_delay_q[i] - {16'd0, r.ticks} : 32'd0;
            if (task_delay_q[i] == 32'd0) begin
              task_delayed_q[i] = 1'b0;
              if (task_level_q[i] < run_level)
                push_result(rtds_pkg::KIND_PREEMPT, 4'(i), 1'b0);
            end
          end
        end
      end
      rtds_pkg::OP_WRITE: begin
        task_delayed_q[r.idx] = r.delayed;
        task_delay_q[r.idx]   = r.delay;
        task_level_q[r.idx]   = r.prio;
      end
      rtds_pkg::OP_SETRUN: begin
        running_q = r.idx;
        slice_q   = r.slice;
      end
      default: ;
    endcase
    push_result(rtds_pkg::KIND_DONE, 4'd0, 1'b1);
  endfunction

  function automatic tick_req_t random_request();
    tick_req_t r;
    r.op      = 2'($urandom_range(3, 0));
    r.ticks   = 16'($urandom());
    r.irq     = 1'($urandom());
    r.idx     = 4'($urandom());
    r.delayed = 1'($urandom());
    r.delay   = $urandom();
    r.prio    = 8'($urandom());
    r.slice   = 16'($urandom());
    return r;
  endfunction

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(7, 0))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(30, 0);
    endcase
  endfunction

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(7, 0))
      0: return 16'($urandom());
      1: return 16'd0;
      default: return 16'($urandom_range(12, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_slice();
    case ($urandom_range(7, 0))
      0: return 16'($urandom());
      1: return 16'd0;
      default: return 16'($urandom_range(40, 1));
    endcase
  endfunction

  task automatic send_request(input tick_req_t r);
    int unsigned gap;
    if (pace_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(8, 1);
        gap = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 8) : $urandom_range(4, 0);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
    end
    op_i            <= r.op;
    elapsed_ticks_i <= r.ticks;
    in_interrupt_i  <= r.irq;
    task_index_i    <= r.idx;
    task_delayed_i  <= r.delayed;
    task_delay_i    <= r.delay;
    task_priority_i <= r.prio;
    slice_length_i  <= r.slice;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_tick_engine(r);
    requests_sent++;
  endtask

  task automatic send_tick(input logic [15:0] ticks, input logic irq);
    tick_req_t r;
    r       = random_request();
    r.op    = rtds_pkg::OP_TICK;
    r.ticks = ticks;
    r.irq   = irq;
    send_request(r);
  endtask

  task automatic send_write(input logic [3:0] idx, input logic delayed,
                            input logic [31:0] delay, input logic [7:0] prio);
    tick_req_t r;
    r         = random_request();
    r.op      = rtds_pkg::OP_WRITE;
    r.idx     = idx;
    r.delayed = delayed;
    r.delay   = delay;
    r.prio    = prio;
    send_request(r);
  endtask

  task automatic send_setrun(input logic [3:0] idx, input logic [15:0] slice);
    tick_req_t r;
    r       = random_request();
    r.op    = rtds_pkg::OP_SETRUN;
    r.idx   = idx;
    r.slice = slice;
    send_request(r);
  endtask

  task automatic test_idle_tick_and_unused_op();
    tick_req_t r;
    send_tick(16'd0, 1'b0);
    r    = random_request();
    r.op = OP_UNUSED;
    send_request(r);
    send_tick(16'hFFFF, 1'b1);
  endtask

  task automatic test_delay_wakeup();
    send_write(4'd3, 1'b1, 32'd0, 8'd0);
    send_tick(16'd0, 1'b0);
    send_write(4'd0, 1'b0, 32'hFFFF_FFFF, 8'd200);
    send_write(4'd5, 1'b1, 32'd10, 8'd199);
    send_write(4'd6, 1'b1, 32'd10, 8'd200);
    send_write(4'd7, 1'b1, 32'hFFFF_FFFF, 8'd0);
    send_write(4'd4, 1'b1, 32'd9, 8'd255);
    send_tick(16'd9, 1'b1);
    send_tick(16'hFFFF, 1'b0);
  endtask

  task automatic test_slice_countdown();
    send_setrun(4'd0, 16'd5);
    send_tick(16'd3, 1'b1);
    send_tick(16'd4, 1'b0);
    send_tick(16'hFFFF, 1'b0);
    send_tick(16'd1, 1'b0);
    send_setrun(4'd5, 16'hFFFF);
    send_write(4'd5, 1'b1, 32'd1, 8'd9);
    send_tick(16'd1, 1'b0);
    send_setrun(4'd15, 16'd0);
    send_tick(16'd2, 1'b0);
  endtask

  task automatic test_wake_storm();
    logic [3:0] run_idx;
    run_idx = 4'($urandom());
    for (int i = 0; i < TASKS; i++) begin
      if (4'(i) == run_idx) send_write(run_idx, 1'b0, $urandom(), 8'd255);
      else send_write(4'(i), 1'b1, $urandom_range(5, 0), 8'($urandom_range(254, 0)));
    end
    send_setrun(run_idx, 16'($urandom_range(5, 1)));
    send_tick(16'd5, 1'b0);
  endtask

  task automatic test_output_backpressure();
    hold_cycles_req = HOLD_CYCLES;
    hold_gen++;
    pace_on = 1'b0;
    repeat (4) send_write(4'($urandom()), 1'b1, $urandom_range(3, 0), 8'($urandom()));
    send_setrun(4'($urandom()), 16'($urandom_range(6, 1)));
    repeat (10) send_tick(16'($urandom_range(2, 0)), 1'b0);
    pace_on = 1'b1;
  endtask

  task automatic test_random_scenes();
    int unsigned stop_at;
    stop_at = requests_sent + RANDOM_ITEMS;
    while (requests_sent < stop_at) begin
      pace_on = ($urandom_range(3, 0) != 0);
      if ($urandom_range(7, 0) == 0) begin
        repeat ($urandom_range(3, 1)) send_request(random_request());
      end else begin
        repeat ($urandom_range(5, 1))
          send_write(4'($urandom()), 1'($urandom_range(4, 0) != 0), pick_delay(),
                     8'($urandom()));
        if ($urandom_range(1, 0) == 1) send_setrun(4'($urandom()), pick_slice());
        repeat ($urandom_range(6, 2))
          send_tick(pick_ticks(), 1'($urandom_range(3, 0) == 0));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    tick_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result expected none actual kind %0d task %0d run_time %0d last %0b",
                 $time, kind_o, task_index_res_o, run_time_o, last_o);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("task_index_res", 32'(want.idx), 32'(task_index_res_o));
        check_field("run_time", want.run_time, run_time_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : result_receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    int unsigned span_left;
    int unsigned mode;
    logic [15:0] pattern;
    logic [3:0]  phase;
    out_ready_i = 1'b0;
    hold_left   = 0;
    hold_seen   = 0;
    span_left   = 0;
    mode        = 0;
    pattern     = 16'hFFFF;
    phase       = 4'd0;
    forever begin
      @(posedge clk_i);
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = hold_cycles_req;
      end
      if (span_left == 0) begin
        span_left = $urandom_range(80, 20);
        mode      = $urandom_range(3, 0);
        pattern   = 16'($urandom()) | 16'h0001;
      end
      span_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(3, 0) == 0);
          default: out_ready_i <= pattern[phase];
        endcase
      end
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    op_i            = rtds_pkg::OP_TICK;
    elapsed_ticks_i = '0;
    in_interrupt_i  = 1'b0;
    task_index_i    = '0;
    task_delayed_i  = 1'b0;
    task_delay_i    = '0;
    task_priority_i = '0;
    slice_length_i  = '0;
    for (int i = 0; i < TASKS; i++) begin
      task_delayed_q[i] = 1'b0;
      task_delay_q[i]   = '0;
      task_level_q[i]   = '0;
    end
    running_q  = '0;
    slice_q    = '0;
    run_time_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_tick_and_unused_op();
    test_delay_wakeup();
    test_slice_countdown();
    test_wake_storm();
    test_output_backpressure();
    test_random_scenes();

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: rtos_tick_delay_slice_unit.f
+incdir+rtl/core
rtl/core/rtds_pkg.sv
rtl/core/rtos_tick_delay_slice_unit.sv
test/tb_top.sv
